// ===== rtl/ipuf_pkg.sv =====
// ipuf_pkg: shared types, codes and constants for the ipv4/udp port filter
// used by ipuf_parser and the ipv4_udp_port_filter top level; no dependencies
package ipuf_pkg;

  // frame byte counter width and default saturation point
  localparam int CountW              = 16;
  localparam int MAX_FRAME_BYTES_DEF = 65535;

  // frame layout
  localparam int ETH_HDR_BYTES   = 14;
  localparam int PROTO_OFFSET    = 23;
  localparam int SRC_ADDR_OFFSET = 26;
  localparam int DST_ADDR_OFFSET = 30;
  localparam int ABS_MIN_LEN     = 24;
  localparam int UDP_HDR_BYTES   = 8;
  localparam int UDP_CAPTURE     = 6;
  localparam int IP_VERSION      = 4;

  // configuration register reset values
  localparam logic [15:0] MATCH_PORT_RESET     = 16'd53;
  localparam logic [15:0] MIN_FRAME_LEN_RESET  = 16'd24;
  localparam logic [7:0]  MATCH_PROTOCOL_RESET = 8'd17;

  // configuration register indexes
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;
  typedef enum logic [CfgIndexW-1:0] {
    CFG_MATCH_PORT     = 2'd0,
    CFG_MIN_FRAME_LEN  = 2'd1,
    CFG_MATCH_PROTOCOL = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_ACCEPT    = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NOT_V4    = 3'd2,
    ST_BAD_PROTO = 3'd3,
    ST_PORT_MISS = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] match_port;
    logic [15:0] min_frame_len;
    logic [7:0]  match_protocol;
  } cfg_t;

  // packed so that status sits in the lowest bits
  typedef struct packed {
    logic [15:0] data_len;
    logic [15:0] udp_dst;
    logic [15:0] udp_src;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
    status_t     status;
  } verdict_t;

  localparam int VerdictW = $bits(verdict_t);
  localparam int OutDataW = ((VerdictW + 7) / 8) * 8;

endpackage

// ===== rtl/ipuf_parser.sv =====
// ipuf_parser: per-frame header capture and verdict logic
// depends on ipuf_pkg; state advances on every accepted byte below the saturation count and clears after the last
module ipuf_parser import ipuf_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  cfg_t       cfg,
  output verdict_t   verdict
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_FRAME_BYTES);

  logic [CountW-1:0] byte_count, byte_count_next;
  logic [3:0]        header_words, header_words_next;
  logic              version_ok, version_ok_next;
  logic              protocol_ok, protocol_ok_next;
  logic [31:0]       source_address, source_address_next;
  logic [31:0]       dest_address, dest_address_next;
  logic [15:0]       source_port_reg, source_port_reg_next;
  logic [15:0]       dest_port_reg, dest_port_reg_next;
  logic [15:0]       udp_length, udp_length_next;

  logic [6:0]        udp_start;
  logic [6:0]        udp_start_next;
  logic [2:0]        udp_off;
  logic              in_udp;

  // capture of the current byte into the frame state
  always_comb begin
    byte_count_next      = byte_count;
    header_words_next    = header_words;
    version_ok_next      = version_ok;
    protocol_ok_next     = protocol_ok;
    source_address_next  = source_address;
    dest_address_next    = dest_address;
    source_port_reg_next = source_port_reg;
    dest_port_reg_next   = dest_port_reg;
    udp_length_next      = udp_length;

    if (byte_count < MaxCount) begin
      if (byte_count == CountW'(ETH_HDR_BYTES)) begin
        version_ok_next   = (data_byte[7:4] == 4'(IP_VERSION));
        header_words_next = data_byte[3:0];
      end
      if (byte_count == CountW'(PROTO_OFFSET)) begin
        protocol_ok_next = (data_byte == cfg.match_protocol);
      end
      for (int k = 0; k < 4; k++) begin
        if (byte_count == CountW'(SRC_ADDR_OFFSET + k)) begin
          source_address_next[8*(3-k) +: 8] = data_byte;
        end
        if (byte_count == CountW'(DST_ADDR_OFFSET + k)) begin
          dest_address_next[8*(3-k) +: 8] = data_byte;
        end
      end
      if (in_udp) begin
        case (udp_off)
          3'd0: source_port_reg_next[15:8] = source_port_reg[15:8] | data_byte;
          3'd1: source_port_reg_next[7:0]  = source_port_reg[7:0] | data_byte;
          3'd2: dest_port_reg_next[15:8]   = dest_port_reg[15:8] | data_byte;
          3'd3: dest_port_reg_next[7:0]    = dest_port_reg[7:0] | data_byte;
          3'd4: udp_length_next[15:8]      = udp_length[15:8] | data_byte;
          3'd5: udp_length_next[7:0]       = udp_length[7:0] | data_byte;
          default: ;
        endcase
      end
      byte_count_next = byte_count + 1'b1;
    end
  end

  // udp header position seen by this byte; the ihl byte uses its own ihl
  always_comb begin
    if (byte_count == CountW'(ETH_HDR_BYTES)) begin
      udp_start = 7'(ETH_HDR_BYTES) + {1'b0, data_byte[3:0], 2'b00};
    end else begin
      udp_start = 7'(ETH_HDR_BYTES) + {1'b0, header_words, 2'b00};
    end
    udp_off = 3'(byte_count - {{(CountW-7){1'b0}}, udp_start});
    in_udp = (byte_count >= CountW'(ETH_HDR_BYTES))
          && (byte_count >= {{(CountW-7){1'b0}}, udp_start})
          && (byte_count < {{(CountW-7){1'b0}}, udp_start} + CountW'(UDP_CAPTURE));
  end

  // verdict from the state as it stands after this byte
  always_comb begin
    udp_start_next = 7'(ETH_HDR_BYTES) + {1'b0, header_words_next, 2'b00};

    if (byte_count_next < cfg.min_frame_len || byte_count_next < CountW'(ABS_MIN_LEN)) begin
      verdict.status = ST_SHORT;
    end else if (!version_ok_next) begin
      verdict.status = ST_NOT_V4;
    end else if (!protocol_ok_next) begin
      verdict.status = ST_BAD_PROTO;
    end else if (byte_count_next <
                 {{(CountW-7){1'b0}}, udp_start_next} + CountW'(UDP_CAPTURE)) begin
      verdict.status = ST_SHORT;
    end else if (source_port_reg_next != cfg.match_port &&
                 dest_port_reg_next != cfg.match_port) begin
      verdict.status = ST_PORT_MISS;
    end else begin
      verdict.status = ST_ACCEPT;
    end

    verdict.src_addr = source_address_next;
    verdict.dst_addr = dest_address_next;
    verdict.udp_src  = source_port_reg_next;
    verdict.udp_dst  = dest_port_reg_next;
    if (udp_length_next < 16'(UDP_HDR_BYTES)) begin
      verdict.data_len = '0;
    end else begin
      verdict.data_len = udp_length_next - 16'(UDP_HDR_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_count      <= '0;
      header_words    <= '0;
      version_ok      <= 1'b0;
      protocol_ok     <= 1'b0;
      source_address  <= '0;
      dest_address    <= '0;
      source_port_reg <= '0;
      dest_port_reg   <= '0;
      udp_length      <= '0;
    end else if (accept) begin
      byte_count      <= byte_count_next;
      header_words    <= header_words_next;
      version_ok      <= version_ok_next;
      protocol_ok     <= protocol_ok_next;
      source_address  <= source_address_next;
      dest_address    <= dest_address_next;
      source_port_reg <= source_port_reg_next;
      dest_port_reg   <= dest_port_reg_next;
      udp_length      <= udp_length_next;
    end
  end

endmodule

// ===== rtl/ipv4_udp_port_filter.sv =====
// output: the verdict for a frame is registered when its last byte is accepted and is valid in the following cycle
// throughput: one byte per cycle; the input stalls in any cycle in which a verdict
// still sits unread in the output register and the receiver is not ready
// reset: registers return to port 53, minimum length 24, protocol 17; frame state clears
// and the output register empties
module ipv4_udp_port_filter import ipuf_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,   // last_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [2:0] status, [34:3] src_addr, [66:35] dst_addr, [82:67] udp_src,
  // [98:83] udp_dst, [114:99] data_len, rest zero
  output logic [OutDataW-1:0]  m_axis_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t     cfg;
  verdict_t verdict;
  verdict_t result;
  logic     out_valid;
  logic     in_accept;
  logic     load;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign load          = in_accept && s_axis_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_port     <= MATCH_PORT_RESET;
      cfg.min_frame_len  <= MIN_FRAME_LEN_RESET;
      cfg.match_protocol <= MATCH_PROTOCOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MATCH_PORT:     cfg.match_port     <= cfg_data;
        CFG_MIN_FRAME_LEN:  cfg.min_frame_len  <= cfg_data;
        CFG_MATCH_PROTOCOL: cfg.match_protocol <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ipuf_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .data_byte (s_axis_tdata),
    .last_byte (s_axis_tlast),
    .cfg       (cfg),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutDataW-VerdictW){1'b0}}, result};

endmodule
